[hw/rtl/fpalu_pkg.sv]
// Package with widths, opcodes and status codes for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpalu_pkg;
  localparam int WordBits = 32;
  localparam int FracBits = 8;
  localparam int NumBits = WordBits + FracBits;
  localparam int QuoBits = NumBits;
  localparam int DivPerStage = 4;
  localparam int DivStages = (QuoBits + DivPerStage - 1) / DivPerStage;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVERFLOW = 2'd1, ST_DIV_ZERO = 2'd2
  } status_t;

  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};
endpackage
`default_nettype wire

[hw/rtl/fixed_point_alu.sv]
// Top level of the pipelined fixed-point ALU.
//   channel  dir  fields (low bit first)
//   s_axis   in   tdata: opcode[3:0], operand_a[35:4], operand_b[67:36], pad to 72
//   m_axis   out  tdata: result_value[31:0], compare_true[32], status[34:33], pad to 40
// Every operation flows through the same pipeline: decode, product, divider stages,
// rounding and output; one transfer is accepted per cycle while the output is not stalled.
// The divider (four quotient bits a stage) sets the depth; all other ops ride along.
// A stall at the output freezes all stages together; no item is lost or repeated.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu import fpalu_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [71:0] s_axis_tdata,  // opcode, operand_a, operand_b
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [39:0] m_axis_tdata  // result_value, compare_true, status
);
  localparam int W = WordBits;
  localparam int N = NumBits;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: decode, magnitudes, simple ops.
  logic            v1;
  opcode_t         op1;
  logic [W-1:0]    ma1, mb1;
  logic            neg1, an1, az1, bz1;
  logic [W-1:0]    sr1;
  logic            sc1;
  status_t         ss1;

  logic signed [W-1:0] ia, ib;
  logic signed [W:0]   sum, dif, inc, dec;
  logic signed [W+FracBits:0] shl;
  logic [W-1:0] sr_c;
  logic sc_c;
  status_t ss_c;
  opcode_t iop;

  assign iop = opcode_t'(s_axis_tdata[3:0]);
  assign ia = s_axis_tdata[35:4];
  assign ib = s_axis_tdata[67:36];

  function automatic logic [W-1:0] sat33(input logic signed [W:0] v, output logic ov);
    ov = v[W] != v[W-1];
    return ov ? (v[W] ? WordMin : WordMax) : v[W-1:0];
  endfunction

  always_comb begin
    logic ov;
    sum = {ia[W-1], ia} + {ib[W-1], ib};
    dif = {ia[W-1], ia} - {ib[W-1], ib};
    inc = {ia[W-1], ia} + (W+1)'(1);
    dec = {ia[W-1], ia} - (W+1)'(1);
    shl = (W+FracBits+1)'({{(FracBits+1){ia[W-1]}}, ia}) <<< FracBits;
    sr_c = '0;
    sc_c = 1'b0;
    ss_c = ST_OK;
    ov = 1'b0;
    case (iop)
      OP_ADD: sr_c = sat33(sum, ov);
      OP_SUB: sr_c = sat33(dif, ov);
      OP_INC: sr_c = sat33(inc, ov);
      OP_DEC: sr_c = sat33(dec, ov);
      OP_GT: sc_c = ia > ib;
      OP_LT: sc_c = ia < ib;
      OP_GE: sc_c = ia >= ib;
      OP_LE: sc_c = ia <= ib;
      OP_EQ: sc_c = ia == ib;
      OP_NE: sc_c = ia != ib;
      OP_MIN: sr_c = (ib < ia) ? ib : ia;
      OP_MAX: sr_c = (ia > ib) ? ia : ib;
      OP_TO_INT: sr_c = W'(ia >>> FracBits);
      OP_FROM_INT: begin
        ov = (shl[W+FracBits:W-1] != {(FracBits+2){1'b0}}) &&
             (shl[W+FracBits:W-1] != {(FracBits+2){1'b1}});
        sr_c = ov ? (ia[W-1] ? WordMin : WordMax) : shl[W-1:0];
      end
      default: sr_c = '0;
    endcase
    if (ov) ss_c = ST_OVERFLOW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
    end
    if (adv) begin
      op1 <= iop;
      ma1 <= ia[W-1] ? W'(-ia) : W'(ia);
      mb1 <= ib[W-1] ? W'(-ib) : W'(ib);
      neg1 <= ia[W-1] ^ ib[W-1];
      an1 <= ia[W-1];
      az1 <= ia == '0;
      bz1 <= ib == '0;
      sr1 <= sr_c;
      sc1 <= sc_c;
      ss1 <= ss_c;
    end
  end

  // Stage 2: magnitude product; divider numerator load.
  logic            v2;
  opcode_t         op2;
  logic [2*W-1:0]  prod2;
  logic [W-1:0]    mb2;
  logic            neg2, an2, az2, bz2, sc2;
  logic [W-1:0]    sr2, ma2;
  status_t         ss2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      op2 <= op1; prod2 <= ma1 * mb1; mb2 <= mb1; ma2 <= ma1;
      neg2 <= neg1; an2 <= an1; az2 <= az1; bz2 <= bz1;
      sr2 <= sr1; sc2 <= sc1; ss2 <= ss1;
    end
  end

  // Divider stages: restoring, DivPerStage quotient bits per stage.
  typedef struct packed {
    logic           v;
    opcode_t        op;
    logic [N-1:0]   num;
    logic [W:0]     rem;
    logic [W-1:0]   den;
    logic [2*W-1:0] prod;
    logic           neg, an, az, bz, sc;
    logic [W-1:0]   sr;
    status_t        ss;
  } dstage_t;

  dstage_t ds [DivStages+1];
  localparam int Pad = DivStages * DivPerStage - N;

  always_comb begin
    ds[0].v = v2; ds[0].op = op2;
    ds[0].num = N'({ma2, {FracBits{1'b0}}});
    ds[0].rem = '0; ds[0].den = mb2; ds[0].prod = prod2;
    ds[0].neg = neg2; ds[0].an = an2; ds[0].az = az2; ds[0].bz = bz2;
    ds[0].sc = sc2; ds[0].sr = sr2; ds[0].ss = ss2;
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    dstage_t nx;
    always_comb begin
      logic [W:0] r;
      logic [N-1:0] q;
      r = ds[g].rem;
      q = ds[g].num;
      nx = ds[g];
      for (int k = 0; k < DivPerStage; k++) begin
        if (g * DivPerStage + k >= Pad) begin
          r = {r[W-1:0], q[N-1]};
          q = {q[N-2:0], 1'b0};
          if (r >= {1'b0, ds[g].den}) begin
            r = r - {1'b0, ds[g].den};
            q[0] = 1'b1;
          end
        end
      end
      nx.rem = r;
      nx.num = q;
    end
    always_ff @(posedge clk) begin
      if (rst) ds[g+1].v <= 1'b0;
      else if (adv) ds[g+1].v <= nx.v;
      if (adv) begin
        ds[g+1].op <= nx.op; ds[g+1].num <= nx.num; ds[g+1].rem <= nx.rem;
        ds[g+1].den <= nx.den; ds[g+1].prod <= nx.prod; ds[g+1].neg <= nx.neg;
        ds[g+1].an <= nx.an; ds[g+1].az <= nx.az; ds[g+1].bz <= nx.bz;
        ds[g+1].sc <= nx.sc; ds[g+1].sr <= nx.sr; ds[g+1].ss <= nx.ss;
      end
    end
  end

  // Rounding stage: round magnitude half away from zero.
  localparam int MB = 2*W - FracBits + 1;
  dstage_t dl;
  assign dl = ds[DivStages];
  logic           vr;
  opcode_t        opr;
  logic [MB-1:0]  mag_r;
  logic           negr, anr, azr, bzr, scr;
  logic [W-1:0]   srr;
  status_t        ssr;

  always_ff @(posedge clk) begin
    logic [2*W:0] pr;
    logic [W:0] twice;
    logic [N:0] qr;
    if (rst) vr <= 1'b0;
    else if (adv) vr <= dl.v;
    if (adv) begin
      pr = {1'b0, dl.prod} + ((2*W+1)'(FracBits > 0) << (FracBits > 0 ? FracBits-1 : 0));
      if (FracBits == 0) pr = {1'b0, dl.prod};
      twice = {dl.rem[W-1:0], 1'b0};
      qr = {1'b0, dl.num} + (N+1)'(twice >= {1'b0, dl.den});
      if (dl.op == OP_DIV) mag_r <= MB'(qr);
      else mag_r <= MB'(pr >> FracBits);
      opr <= dl.op; negr <= dl.neg; anr <= dl.an; azr <= dl.az; bzr <= dl.bz;
      scr <= dl.sc; srr <= dl.sr; ssr <= dl.ss;
    end
  end

  // Output stage: sign, saturation, packing.
  logic [W-1:0] ov_r;
  logic         oc_r;
  status_t      os_r;

  always_ff @(posedge clk) begin
    logic big;
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vr;
    if (adv) begin
      big = negr ? (mag_r > MB'({1'b1, {(W-1){1'b0}}}))
                 : (mag_r > MB'({1'b0, {(W-1){1'b1}}}));
      ov_r <= srr; oc_r <= scr; os_r <= ssr;
      if (opr == OP_MUL || opr == OP_DIV) begin
        if (opr == OP_DIV && bzr) begin
          os_r <= ST_DIV_ZERO;
          ov_r <= azr ? '0 : (anr ? WordMin : WordMax);
        end else if (big) begin
          os_r <= ST_OVERFLOW;
          ov_r <= negr ? WordMin : WordMax;
        end else begin
          os_r <= ST_OK;
          ov_r <= negr ? W'(-mag_r) : W'(mag_r);
        end
      end
    end
  end

  assign m_axis_tdata = {5'd0, os_r, oc_r, ov_r};
endmodule
`default_nettype wire

[hw/rtl/fpalu_checker.sv]
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpalu_checker import fpalu_pkg::*; (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [71:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0 && m_axis_tdata[34:33] != 2'd3)
    else $error("bad status or padding");
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0 &&
    m_axis_tdata[34:33] == 2'd0)
    else $error("comparison result not clean");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind fixed_point_alu fpalu_checker u_fpalu_checker (.*);
`default_nettype wire

[test/fpalu_checker.sv]
// Checker that predicts and compares every result of the fixed-point ALU.
`timescale 1ns / 1ps
module fpalu_scoreboard import fpalu_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [71:0] s_axis_tdata,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [39:0] m_axis_tdata,
  output int         fail_count,
  output int         pending_count,
  output int         result_count
);
  typedef struct packed {
    logic [1:0] status;
    logic cmp;
    logic [31:0] value;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic [31:0] saturate(input logic signed [127:0] v, inout logic [1:0] st);
    if (v > 128'sd2147483647) begin
      st = ST_OVERFLOW;
      return WordMax;
    end else if (v < -128'sd2147483648) begin
      st = ST_OVERFLOW;
      return WordMin;
    end
    return v[31:0];
  endfunction

  function automatic alu_result_t predict_alu(input logic [71:0] d);
    opcode_t op;
    logic signed [127:0] a, b, ma, mb, p, q, r;
    alu_result_t res;
    logic [1:0] st;
    op = opcode_t'(d[3:0]);
    a = $signed(d[35:4]);
    b = $signed(d[67:36]);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    st = ST_OK;
    res = '0;
    case (op)
      OP_ADD: res.value = saturate(a + b, st);
      OP_SUB: res.value = saturate(a - b, st);
      OP_MUL: begin
        p = (ma * mb + (128'sd1 <<< (FracBits - 1))) >>> FracBits;
        if ((a < 0) != (b < 0)) p = -p;
        res.value = saturate(p, st);
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIV_ZERO;
          res.value = a == 0 ? 32'd0 : (a < 0 ? WordMin : WordMax);
        end else begin
          q = (ma <<< FracBits) / mb;
          r = (ma <<< FracBits) % mb;
          if (r >= mb - r) q = q + 1;
          if ((a < 0) != (b < 0)) q = -q;
          res.value = saturate(q, st);
        end
      end
      OP_GT: res.cmp = a > b;
      OP_LT: res.cmp = a < b;
      OP_GE: res.cmp = a >= b;
      OP_LE: res.cmp = a <= b;
      OP_EQ: res.cmp = a == b;
      OP_NE: res.cmp = a != b;
      OP_INC: res.value = saturate(a + 1, st);
      OP_DEC: res.value = saturate(a - 1, st);
      OP_MIN: res.value = b < a ? b[31:0] : a[31:0];
      OP_MAX: res.value = a > b ? a[31:0] : b[31:0];
      OP_TO_INT: begin
        p = a >>> FracBits;
        res.value = p[31:0];
      end
      default: res.value = saturate(a <<< FracBits, st);
    endcase
    res.status = st;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    alu_result_t want, got;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_results.push_back(predict_alu(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[34:0];
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value || got.cmp !== want.cmp || got.status !== want.status) begin
            $display("%0t: mismatch value/cmp/status expected %h/%b/%0d actual %h/%b/%0d",
                     $time, want.value, want.cmp, want.status, got.value, got.cmp, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[test/tb.sv]
// Testbench top that drives the fixed-point ALU and reports the verdict.
`timescale 1ns / 1ps
module tb import fpalu_pkg::*;;
  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tready = 1'b0;
  wire s_axis_tready, m_axis_tvalid;
  wire [39:0] m_axis_tdata;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  int sent_count = 0;
  logic [31:0] edge_vals[8] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF,
                                32'h80000000, 32'h100, 32'hFFFFFF00, 32'h180};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  fixed_point_alu DUT (.*);

  fpalu_scoreboard u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    int phase;
    phase = cycle_count % 200;
    if (phase < 40) m_axis_tready <= 1'b1;
    else if (phase < 120) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 2) == 0);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return edge_vals[$urandom_range(0, 7)];
      1: return $urandom();
      2: return $urandom_range(0, 4095) - 2048;
      3: return ($urandom_range(0, 255) - 128) << 8;
      4: return $urandom() >>> $urandom_range(8, 24);
      default: return $urandom_range(0, 65535) << $urandom_range(0, 16);
    endcase
  endfunction

  task automatic send_op(input opcode_t op, input logic [31:0] a, input logic [31:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, b, a, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  initial begin
    int burst, gap, settle;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 16; i++) send_op(opcode_t'(i), edge_vals[i % 8], edge_vals[(i + 3) % 8]);
    send_op(OP_DIV, 32'h0, 32'h0);
    send_op(OP_DIV, 32'h80000000, 32'h0);
    send_op(OP_DIV, 32'h7FFFFFFF, 32'h1);
    send_op(OP_MUL, 32'h80000000, 32'h80000000);
    send_op(OP_MUL, 32'h00000080, 32'hFFFFFF80);
    send_op(OP_DIV, 32'h00000001, 32'h00000200);
    send_op(OP_FROM_INT, 32'h80000000, 32'h0);
    send_op(OP_TO_INT, 32'hFFFFFFFF, 32'h0);
    send_op(OP_SUB, 32'h80000000, 32'h1);
    while (sent_count < 775) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_op(opcode_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    settle = 0;
    while (settle < 40) begin
      @(posedge clk);
      settle++;
    end
    $display("Sent %0d operations over all sixteen opcodes, including edge operands;", sent_count);
    $display("checked %0d results under random input gaps and output stalls.", result_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
